>>> rtl/core/rsk_pkg.sv
// Shared types and constants for the record sorter.
// Holds the request, result and stored record layouts and the key length.
// No dependencies.
package rsk_pkg;

  // Key bytes that take part in the compare (the rest are stored only)
  localparam int KEY_BYTES = 30;
  localparam int KEY_W = 256;

  typedef struct packed {
    logic signed [31:0] emp_id;
    logic signed [31:0] pay;
    logic [63:0]        name_word0;
    logic [63:0]        name_word1;
    logic [63:0]        name_word2;
    logic [63:0]        name_word3;
    logic               last_record;
  } rsk_req_t;

  typedef struct packed {
    logic signed [31:0] out_id;
    logic signed [31:0] out_pay;
    logic [63:0]        out_word0;
    logic [63:0]        out_word1;
    logic [63:0]        out_word2;
    logic [63:0]        out_word3;
    logic               overflowed;
    logic               last_out;
  } rsk_res_t;

  typedef struct packed {
    logic [31:0]      id;
    logic [31:0]      pay;
    logic [KEY_W-1:0] key;
  } rsk_rec_t;

endpackage

>>> rtl/core/rsk_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rsk_ram #(
  parameter int WIDTH = 320,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/rsk_key_cmp.sv
// Name key compare: bytewise unsigned, first differing byte decides,
// a byte that is zero in both keys ends the compare as equal.
// Depends on rsk_pkg.
module rsk_key_cmp
  import rsk_pkg::*;
(
  input  logic [KEY_W-1:0] a_key,
  input  logic [KEY_W-1:0] b_key,
  output logic             greater
);

  logic [7:0] xb;
  logic [7:0] yb;

  // Walk from the last compared byte down so the earliest deciding byte wins
  always_comb begin
    greater = 1'b0;
    xb = '0;
    yb = '0;
    for (int k = KEY_BYTES - 1; k >= 0; k--) begin
      xb = a_key[KEY_W-1-8*k -: 8];
      yb = b_key[KEY_W-1-8*k -: 8];
      if (xb != yb) begin
        greater = (xb > yb);
      end else if (xb == 8'd0) begin
        greater = 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/record_sort_by_name_key.sv
// Record sorter top level: loads records into a record RAM, exchange-sorts
// them by name key on the last record and streams them out in order.
// Depends on rsk_pkg, rsk_ram and rsk_key_cmp.
//
//   channel   handshake            payload   notes
//   request   start / busy         req       taken when start && !busy
//   result    strobe (one cycle)   rsp       no back-pressure
//
// A request that does not end a set leaves the sorter idle and ready for the
// next. On the last record the sort runs over the n stored records: a
// prefetch read, then per outer pass a fetch, one compare per remaining
// record and a write-back, then one emit read per record. The record RAM
// has one read port and reads one record per cycle.
// Synchronous reset clears the control state; RAM contents stay undefined.
// busy stays high from the last record through the final emit read and drops
// in the cycle the final result is strobed.
module record_sort_by_name_key
  import rsk_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  rsk_req_t req,
  output logic     strobe,
  output rsk_res_t rsp
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int REC_W = $bits(rsk_rec_t);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_FETCH = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WB    = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] record_count;
  logic [CNT_W-1:0] record_count_next;
  logic             drop_flag;
  logic             drop_flag_next;
  logic [IDX_W-1:0] outer_index;
  logic [IDX_W-1:0] outer_index_next;
  logic [IDX_W-1:0] inner_index;
  logic [IDX_W-1:0] inner_index_next;
  logic [IDX_W-1:0] last_index;
  logic [IDX_W-1:0] last_index_next;
  rsk_rec_t         hold;
  rsk_rec_t         hold_next;
  logic             ovf_out;
  logic             last_flag;

  logic             accept;
  logic             has_room;
  logic [CNT_W-1:0] fill_after;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [REC_W-1:0] ram_rdata;
  rsk_rec_t         rd_rec;
  rsk_rec_t         in_rec;
  logic             swap;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign has_room = (record_count < CNT_W'(MAX_RECORDS));
  assign fill_after = has_room ? record_count + CNT_W'(1) : record_count;
  assign rd_rec   = rsk_rec_t'(ram_rdata);

  assign in_rec.id  = req.emp_id;
  assign in_rec.pay = req.pay;
  assign in_rec.key = {req.name_word0, req.name_word1, req.name_word2, req.name_word3};

  rsk_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rsk_key_cmp u_cmp (
    .a_key  (hold.key),
    .b_key  (rd_rec.key),
    .greater(swap)
  );

  always_comb begin
    state_next        = state;
    record_count_next = record_count;
    drop_flag_next    = drop_flag;
    outer_index_next  = outer_index;
    inner_index_next  = inner_index;
    last_index_next   = last_index;
    hold_next         = hold;
    ram_we            = 1'b0;
    ram_waddr         = inner_index;
    ram_wdata         = REC_W'(hold);
    ram_raddr         = inner_index;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            ram_we            = 1'b1;
            ram_waddr         = record_count[IDX_W-1:0];
            ram_wdata         = REC_W'(in_rec);
            record_count_next = fill_after;
          end else begin
            drop_flag_next = 1'b1;
          end
          if (req.last_record) begin
            last_index_next = IDX_W'(fill_after - CNT_W'(1));
            outer_index_next = '0;
            if (fill_after >= CNT_W'(2)) begin
              inner_index_next = IDX_W'(1);
              state_next       = ST_LOAD;
            end else begin
              inner_index_next = '0;
              state_next       = ST_EMIT;
            end
          end
        end
      end
      ST_LOAD: begin
        ram_raddr  = outer_index;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        // record i arrives; start reading record j
        hold_next  = rd_rec;
        ram_raddr  = inner_index;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (swap) begin
          ram_we    = 1'b1;
          ram_waddr = inner_index;
          ram_wdata = REC_W'(hold);
          hold_next = rd_rec;
        end
        ram_raddr = inner_index + IDX_W'(1);
        if (inner_index == last_index) begin
          state_next = ST_WB;
        end else begin
          inner_index_next = inner_index + IDX_W'(1);
        end
      end
      ST_WB: begin
        // write back position i, prefetch the next i
        ram_we    = 1'b1;
        ram_waddr = outer_index;
        ram_wdata = REC_W'(hold);
        ram_raddr = outer_index + IDX_W'(1);
        if (outer_index + IDX_W'(1) < last_index) begin
          outer_index_next = outer_index + IDX_W'(1);
          inner_index_next = outer_index + IDX_W'(2);
          state_next       = ST_FETCH;
        end else begin
          outer_index_next = '0;
          inner_index_next = '0;
          state_next       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ram_raddr = inner_index;
        if (inner_index == last_index) begin
          record_count_next = '0;
          drop_flag_next    = 1'b0;
          inner_index_next  = '0;
          state_next        = ST_IDLE;
        end else begin
          inner_index_next = inner_index + IDX_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      record_count <= '0;
      drop_flag    <= 1'b0;
      outer_index  <= '0;
      inner_index  <= '0;
      last_index   <= '0;
      strobe       <= 1'b0;
      ovf_out      <= 1'b0;
      last_flag    <= 1'b0;
    end else begin
      state        <= state_next;
      record_count <= record_count_next;
      drop_flag    <= drop_flag_next;
      outer_index  <= outer_index_next;
      inner_index  <= inner_index_next;
      last_index   <= last_index_next;
      strobe       <= (state == ST_EMIT);
      ovf_out      <= drop_flag;
      last_flag    <= (state == ST_EMIT) && (inner_index == last_index);
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

  assign rsp.out_id     = rd_rec.id;
  assign rsp.out_pay    = rd_rec.pay;
  assign rsp.out_word0  = rd_rec.key[255:192];
  assign rsp.out_word1  = rd_rec.key[191:128];
  assign rsp.out_word2  = rd_rec.key[127:64];
  assign rsp.out_word3  = rd_rec.key[63:0];
  assign rsp.overflowed = ovf_out;
  assign rsp.last_out   = last_flag;

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_EMIT))
    else $error("result strobe without an emit read");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_last_with_strobe: assert property (@(posedge clk) disable iff (rst)
    rsp.last_out |-> strobe)
    else $error("last flag without a result");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (inner_index > outer_index && inner_index <= last_index))
    else $error("inner index out of range during sort");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && req.last_record) |=> busy)
    else $error("last record did not start the sort");

endmodule
